// ===== rtl/gnc_pkg.sv =====
// Shared constants and types for the grid neighbor connection block.
package gnc_pkg;

  localparam int unsigned SizeW     = 24;  // Q16.8 cell size code
  localparam int unsigned AreaW     = 32;  // Q24.8 half-area code
  localparam int unsigned AreaFW    = AreaW + 1;  // area plus saturation flag
  localparam int unsigned CellW     = 26;
  localparam int unsigned RowCells  = 256;
  localparam int unsigned PlaneCells = 65536;
  localparam int unsigned RowAW     = $clog2(RowCells);
  localparam int unsigned PlaneAW   = $clog2(PlaneCells);
  localparam int unsigned XSizeW    = 9;
  localparam int unsigned YSizeW    = 9;
  localparam int unsigned ZSizeW    = 11;
  localparam int unsigned PosZW     = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [XSizeW-1:0] XMax = XSizeW'(256);
  localparam logic [YSizeW-1:0] YMax = YSizeW'(256);
  localparam logic [ZSizeW-1:0] ZMax = ZSizeW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_SIZE = 2'd0,
    CFG_Y_SIZE = 2'd1,
    CFG_Z_SIZE = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_X    = 2'd1,
    DIR_Y    = 2'd2,
    DIR_Z    = 2'd3
  } dir_e;

  typedef logic [AreaFW-1:0] area_t;

  // Handshake between the sequencer and the half-area unit.
  typedef struct packed {
    logic start;
  } area_req_t;

  typedef struct packed {
    logic  done;
    area_t area;
  } area_rsp_t;

endpackage

// ===== rtl/grid_neighbor_connections_top.sv =====
// Top level: grid walker, neighbor stores and connection output sequencer.
//
//   channel  | direction | handshake                  | payload
//   cell     | in        | cell_valid_i / cell_ready_o | cell_dx_i, cell_dy_i, cell_dz_i
//   conn     | out       | conn_valid_o / conn_ready_i | lower_cell_o .. last_o
//   cfg      | in        | cfg_we_i (no wait)          | cfg_index_i, cfg_wdata_i
//
// After a cell is accepted, the half-area unit works on each of the three
// axes in turn (start, one multiply, one range check, 32 restoring division
// steps, result handoff), and then the connections are offered one by one;
// an axis that saturates or has a zero divisor skips the division steps.
// Reset clears the walker position and sets the sizes to 1; the row and plane stores are
// never read before the current pass wrote them and need no clearing.
// A stalled connection holds in the output register; the next cell is taken
// only after the previous cell's stores are written back.
module grid_neighbor_connections_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cell_valid_i,
  output logic                          cell_ready_o,
  input  logic [gnc_pkg::SizeW-1:0]     cell_dx_i,
  input  logic [gnc_pkg::SizeW-1:0]     cell_dy_i,
  input  logic [gnc_pkg::SizeW-1:0]     cell_dz_i,
  output logic                          conn_valid_o,
  input  logic                          conn_ready_i,
  output logic [gnc_pkg::CellW-1:0]     lower_cell_o,
  output logic [gnc_pkg::CellW-1:0]     upper_cell_o,
  output logic [1:0]                    direction_o,
  output logic [gnc_pkg::AreaW-1:0]     lower_area_o,
  output logic [gnc_pkg::AreaW-1:0]     upper_area_o,
  output logic                          saturated_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [gnc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gnc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_LOAD,
    ST_OUT,
    ST_WRITE
  } state_e;

  localparam int unsigned PlaneSzW = gnc_pkg::XSizeW + gnc_pkg::YSizeW;

  state_e                         state_q;
  logic [gnc_pkg::XSizeW-1:0]     x_size_q;
  logic [gnc_pkg::YSizeW-1:0]     y_size_q;
  logic [gnc_pkg::ZSizeW-1:0]     z_size_q;
  logic [gnc_pkg::RowAW-1:0]      pos_x_q;
  logic [gnc_pkg::RowAW-1:0]      pos_y_q;
  logic [gnc_pkg::PosZW-1:0]      pos_z_q;
  logic [gnc_pkg::PlaneAW-1:0]    plane_q;
  logic [gnc_pkg::CellW-1:0]      cell_q;
  logic [gnc_pkg::SizeW-1:0]      dx_q, dy_q, dz_q;
  logic [1:0]                     axis_q;
  gnc_pkg::area_t                 ax_q, ay_q, az_q, left_q;
  logic [2:0]                     pend_q;
  logic                           out_valid_q;
  logic [gnc_pkg::CellW-1:0]      lower_q;
  gnc_pkg::dir_e                  dir_q;
  gnc_pkg::area_t                 lo_area_q, up_area_q;
  logic                           last_q;

  logic [gnc_pkg::XSizeW-1:0]     ex;
  logic [gnc_pkg::YSizeW-1:0]     ey;
  logic [gnc_pkg::ZSizeW-1:0]     ez;
  logic [PlaneSzW-1:0]            plane_cells;
  logic                           accept;
  logic [gnc_pkg::SizeW-1:0]      op_a, op_b, op_c;
  gnc_pkg::area_req_t             area_req;
  gnc_pkg::area_rsp_t             area_rsp;
  gnc_pkg::area_t                 row_rdata, plane_rdata;
  logic                           wr_en;
  logic [gnc_pkg::XSizeW-1:0]     px_next;
  logic [gnc_pkg::XSizeW-1:0]     py_next;
  logic [gnc_pkg::ZSizeW-1:0]     pz_next;

  // Clamp the size registers to the grid the stores can hold.
  assign ex = (x_size_q == '0) ? gnc_pkg::XSizeW'(1) :
              (x_size_q > gnc_pkg::XMax) ? gnc_pkg::XMax : x_size_q;
  assign ey = (y_size_q == '0) ? gnc_pkg::YSizeW'(1) :
              (y_size_q > gnc_pkg::YMax) ? gnc_pkg::YMax : y_size_q;
  assign ez = (z_size_q == '0) ? gnc_pkg::ZSizeW'(1) :
              (z_size_q > gnc_pkg::ZMax) ? gnc_pkg::ZMax : z_size_q;
  assign plane_cells = PlaneSzW'(ex) * PlaneSzW'(ey);

  assign cell_ready_o = (state_q == ST_IDLE);
  assign accept       = cell_valid_i && cell_ready_o;
  assign wr_en        = (state_q == ST_WRITE);

  // Operand order per axis: x uses dy*dz/dx, y dz*dx/dy, z dx*dy/dz.
  always_comb begin
    unique case (axis_q)
      2'd0:    begin op_a = dy_q; op_b = dz_q; op_c = dx_q; end
      2'd1:    begin op_a = dz_q; op_b = dx_q; op_c = dy_q; end
      default: begin op_a = dx_q; op_b = dy_q; op_c = dz_q; end
    endcase
  end

  assign area_req.start = (state_q == ST_START);

  gnc_area u_area (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (area_req),
    .a_i   (op_a),
    .b_i   (op_b),
    .c_i   (op_c),
    .rsp_o (area_rsp)
  );

  // Read the neighbor entries as the cell is taken; the data holds until
  // the next cell, and write-back happens before that read.
  gnc_ram #(
    .Width(gnc_pkg::AreaFW),
    .Depth(gnc_pkg::RowCells)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(pos_x_q),
    .wdata_i(ay_q),
    .re_i   (accept),
    .raddr_i(pos_x_q),
    .rdata_o(row_rdata)
  );

  gnc_ram #(
    .Width(gnc_pkg::AreaFW),
    .Depth(gnc_pkg::PlaneCells)
  ) u_plane_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(plane_q),
    .wdata_i(az_q),
    .re_i   (accept),
    .raddr_i(plane_q),
    .rdata_o(plane_rdata)
  );

  assign px_next = gnc_pkg::XSizeW'(pos_x_q) + 1'b1;
  assign py_next = gnc_pkg::XSizeW'(pos_y_q) + 1'b1;
  assign pz_next = gnc_pkg::ZSizeW'(pos_z_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_size_q    <= gnc_pkg::XSizeW'(1);
      y_size_q    <= gnc_pkg::YSizeW'(1);
      z_size_q    <= gnc_pkg::ZSizeW'(1);
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      plane_q     <= '0;
      cell_q      <= '0;
      axis_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Any size register write restarts the grid.
      if (cfg_we_i && gnc_pkg::cfg_idx_e'(cfg_index_i) != gnc_pkg::CFG_NONE) begin
        unique case (gnc_pkg::cfg_idx_e'(cfg_index_i))
          gnc_pkg::CFG_X_SIZE: x_size_q <= cfg_wdata_i[gnc_pkg::XSizeW-1:0];
          gnc_pkg::CFG_Y_SIZE: y_size_q <= cfg_wdata_i[gnc_pkg::YSizeW-1:0];
          default:             z_size_q <= cfg_wdata_i;
        endcase
        pos_x_q <= '0;
        pos_y_q <= '0;
        pos_z_q <= '0;
        plane_q <= '0;
        cell_q  <= '0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            dx_q    <= cell_dx_i;
            dy_q    <= cell_dy_i;
            dz_q    <= cell_dz_i;
            pend_q  <= {pos_z_q != '0, pos_y_q != '0, pos_x_q != '0};
            axis_q  <= '0;
            state_q <= ST_START;
          end
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (area_rsp.done) begin
            unique case (axis_q)
              2'd0:    ax_q <= area_rsp.area;
              2'd1:    ay_q <= area_rsp.area;
              default: az_q <= area_rsp.area;
            endcase
            if (axis_q == 2'd2) begin
              state_q <= ST_LOAD;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= ST_START;
            end
          end
        end
        ST_LOAD: begin
          // Emit in x, y, z order; drop each pending bit once taken.
          priority if (pend_q[0]) begin
            lower_q   <= cell_q - 1'b1;
            dir_q     <= gnc_pkg::DIR_X;
            lo_area_q <= left_q;
            up_area_q <= ax_q;
            last_q    <= (pend_q[2:1] == '0);
            pend_q[0] <= 1'b0;
            out_valid_q <= 1'b1;
            state_q   <= ST_OUT;
          end else if (pend_q[1]) begin
            lower_q   <= cell_q - gnc_pkg::CellW'(ex);
            dir_q     <= gnc_pkg::DIR_Y;
            lo_area_q <= row_rdata;
            up_area_q <= ay_q;
            last_q    <= !pend_q[2];
            pend_q[1] <= 1'b0;
            out_valid_q <= 1'b1;
            state_q   <= ST_OUT;
          end else if (pend_q[2]) begin
            lower_q   <= cell_q - gnc_pkg::CellW'(plane_cells);
            dir_q     <= gnc_pkg::DIR_Z;
            lo_area_q <= plane_rdata;
            up_area_q <= az_q;
            last_q    <= 1'b1;
            pend_q[2] <= 1'b0;
            out_valid_q <= 1'b1;
            state_q   <= ST_OUT;
          end else begin
            state_q <= ST_WRITE;
          end
        end
        ST_OUT: begin
          if (conn_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_LOAD;
          end
        end
        ST_WRITE: begin
          // Stores are written this edge; advance the walker.
          left_q <= ax_q;
          if (px_next >= ex) begin
            pos_x_q <= '0;
            if (py_next >= gnc_pkg::XSizeW'(ey)) begin
              pos_y_q <= '0;
              plane_q <= '0;
              if (pz_next >= ez) begin
                pos_z_q <= '0;
                cell_q  <= '0;
              end else begin
                pos_z_q <= pz_next[gnc_pkg::PosZW-1:0];
                cell_q  <= cell_q + 1'b1;
              end
            end else begin
              pos_y_q <= py_next[gnc_pkg::RowAW-1:0];
              plane_q <= plane_q + 1'b1;
              cell_q  <= cell_q + 1'b1;
            end
          end else begin
            pos_x_q <= px_next[gnc_pkg::RowAW-1:0];
            plane_q <= plane_q + 1'b1;
            cell_q  <= cell_q + 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign conn_valid_o = out_valid_q;
  assign lower_cell_o = lower_q;
  assign upper_cell_o = cell_q;
  assign direction_o  = dir_q;
  assign lower_area_o = lo_area_q[gnc_pkg::AreaW-1:0];
  assign upper_area_o = up_area_q[gnc_pkg::AreaW-1:0];
  assign saturated_o  = lo_area_q[gnc_pkg::AreaW] | up_area_q[gnc_pkg::AreaW];
  assign last_o       = last_q;

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ready_o |-> !conn_valid_o)
    else $error("cell taken while a connection is pending");

  a_pos_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (gnc_pkg::XSizeW'(pos_x_q) < ex))
    else $error("walker x position beyond row");

  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conn_valid_o && last_o) |-> (pend_q == '0))
    else $error("last connection while others pending");
`endif

endmodule

// ===== rtl/gnc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gnc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gnc_area.sv =====
// Half-area unit: floor(2*a*b/c) with saturation, one quotient bit per cycle.
module gnc_area (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gnc_pkg::area_req_t          req_i,
  input  logic [gnc_pkg::SizeW-1:0]   a_i,
  input  logic [gnc_pkg::SizeW-1:0]   b_i,
  input  logic [gnc_pkg::SizeW-1:0]   c_i,
  output gnc_pkg::area_rsp_t          rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV
  } state_e;

  localparam int unsigned ProdW = 2 * gnc_pkg::SizeW;
  localparam int unsigned NumW  = ProdW + 1;
  localparam int unsigned QW    = gnc_pkg::AreaW;
  localparam int unsigned HiW   = NumW - QW;
  localparam int unsigned CntW  = $clog2(QW);

  state_e                     state_q;
  logic [ProdW-1:0]           prod_q;
  logic [gnc_pkg::SizeW-1:0]  rem_q;
  logic [QW-1:0]              low_q;
  logic [QW-1:0]              quo_q;
  logic [CntW-1:0]            cnt_q;
  logic                       done_q;
  gnc_pkg::area_t             area_q;

  logic [NumW-1:0]            num;
  logic [HiW-1:0]             num_hi;
  logic [gnc_pkg::SizeW:0]    trial;
  logic                       ge;
  logic [gnc_pkg::SizeW:0]    diff;
  logic [QW-1:0]              quo_next;

  assign num      = {prod_q, 1'b0};
  assign num_hi   = num[NumW-1:QW];
  assign trial    = {rem_q, low_q[QW-1]};
  assign ge       = trial >= {1'b0, c_i};
  assign diff     = trial - {1'b0, c_i};
  assign quo_next = {quo_q[QW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= a_i * b_i;
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          // Quotient overflows 32 bits exactly when the high part reaches c.
          if (c_i == '0 || {{(gnc_pkg::SizeW-HiW){1'b0}}, num_hi} >= c_i) begin
            area_q  <= {1'b1, {QW{1'b1}}};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            rem_q   <= {{(gnc_pkg::SizeW-HiW){1'b0}}, num_hi};
            low_q   <= num[QW-1:0];
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= ge ? diff[gnc_pkg::SizeW-1:0] : trial[gnc_pkg::SizeW-1:0];
          low_q <= {low_q[QW-2:0], 1'b0};
          quo_q <= quo_next;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(QW - 1)) begin
            area_q  <= {1'b0, quo_next};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.area = area_q;

endmodule

// ===== tb/grid_neighbor_connections_top_test.sv =====
// Self-checking testbench for the grid neighbor connection block.
module grid_neighbor_connections_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  // Quiet cycles that cover one cell with no connection.
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic [gnc_pkg::SizeW-1:0] dx;
    logic [gnc_pkg::SizeW-1:0] dy;
    logic [gnc_pkg::SizeW-1:0] dz;
    int unsigned               gap;
  } cell_item_t;

  typedef struct {
    logic [gnc_pkg::CellW-1:0] lower_cell;
    logic [gnc_pkg::CellW-1:0] upper_cell;
    gnc_pkg::dir_e             direction;
    logic [gnc_pkg::AreaW-1:0] lower_area;
    logic [gnc_pkg::AreaW-1:0] upper_area;
    logic                      saturated;
    logic                      last;
  } conn_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cell_valid_i = 1'b0;
  logic cell_ready_o;
  logic [gnc_pkg::SizeW-1:0] cell_dx_i = '0;
  logic [gnc_pkg::SizeW-1:0] cell_dy_i = '0;
  logic [gnc_pkg::SizeW-1:0] cell_dz_i = '0;
  logic conn_valid_o;
  logic conn_ready_i = 1'b0;
  logic [gnc_pkg::CellW-1:0] lower_cell_o;
  logic [gnc_pkg::CellW-1:0] upper_cell_o;
  logic [1:0] direction_o;
  logic [gnc_pkg::AreaW-1:0] lower_area_o;
  logic [gnc_pkg::AreaW-1:0] upper_area_o;
  logic saturated_o;
  logic last_o;
  logic cfg_we_i = 1'b0;
  logic [gnc_pkg::CfgIdxW-1:0] cfg_index_i = gnc_pkg::CFG_NONE;
  logic [gnc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  grid_neighbor_connections_top dut (.*);

  always #4 clk_i = ~clk_i;

  // Pending cells, offered front first, and connections still owed by the block.
  cell_item_t cell_q[$];
  conn_item_t conn_q[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  // Mirror of the block's walker and stores.
  logic [gnc_pkg::XSizeW-1:0] x_reg;
  logic [gnc_pkg::YSizeW-1:0] y_reg;
  logic [gnc_pkg::ZSizeW-1:0] z_reg;
  int unsigned pos_x, pos_y, pos_z;
  logic [gnc_pkg::CellW-1:0] cell_idx;
  gnc_pkg::area_t left_area;
  gnc_pkg::area_t row_area [gnc_pkg::RowCells];
  gnc_pkg::area_t plane_area [gnc_pkg::PlaneCells];

  function automatic gnc_pkg::area_t half_area(logic [gnc_pkg::SizeW-1:0] a,
                                               logic [gnc_pkg::SizeW-1:0] b,
                                               logic [gnc_pkg::SizeW-1:0] c);
    logic [63:0] q;
    if (c == '0) return {1'b1, 32'hFFFF_FFFF};
    q = (64'(a) * 64'(b) * 64'd2) / 64'(c);
    if (q > 64'hFFFF_FFFF) return {1'b1, 32'hFFFF_FFFF};
    return {1'b0, q[31:0]};
  endfunction

  function automatic conn_item_t make_conn(logic [gnc_pkg::CellW-1:0] lower,
                                           gnc_pkg::dir_e dir,
                                           gnc_pkg::area_t lo, gnc_pkg::area_t up);
    conn_item_t c;
    c.lower_cell = lower;
    c.upper_cell = cell_idx;
    c.direction  = dir;
    c.lower_area = lo[gnc_pkg::AreaW-1:0];
    c.upper_area = up[gnc_pkg::AreaW-1:0];
    c.saturated  = lo[gnc_pkg::AreaW] | up[gnc_pkg::AreaW];
    c.last       = 1'b0;
    return c;
  endfunction

  // Work out the connections of one accepted cell and advance the walker.
  task automatic predict_connections(cell_item_t it);
    int unsigned ex, ey, ez, px, py, plane_at, cap;
    gnc_pkg::area_t ax, ay, az;
    conn_item_t found[$];
    ex = 32'(x_reg);
    if (ex < 1) ex = 1;
    if (ex > gnc_pkg::RowCells) ex = gnc_pkg::RowCells;
    ey = 32'(y_reg);
    cap = gnc_pkg::PlaneCells / ex;
    if (ey > 256) ey = 256;
    if (ey > cap) ey = cap;
    if (ey < 1) ey = 1;
    ez = 32'(z_reg);
    if (ez < 1) ez = 1;
    if (ez > 1024) ez = 1024;
    ax = half_area(it.dy, it.dz, it.dx);
    ay = half_area(it.dz, it.dx, it.dy);
    az = half_area(it.dx, it.dy, it.dz);
    px = (pos_x < ex) ? pos_x : 0;
    py = (pos_y < ey) ? pos_y : 0;
    plane_at = px + py * ex;
    if (px > 0) begin
      found = {found, make_conn(cell_idx - gnc_pkg::CellW'(1), gnc_pkg::DIR_X,
                                left_area, ax)};
    end
    if (py > 0) begin
      found = {found, make_conn(cell_idx - gnc_pkg::CellW'(ex), gnc_pkg::DIR_Y,
                                row_area[px], ay)};
    end
    if (pos_z > 0) begin
      found = {found, make_conn(cell_idx - gnc_pkg::CellW'(ex * ey), gnc_pkg::DIR_Z,
                                plane_area[plane_at], az)};
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) conn_q = {conn_q, found[i]};
    left_area = ax;
    row_area[px] = ay;
    plane_area[plane_at] = az;
    px++;
    cell_idx = cell_idx + gnc_pkg::CellW'(1);
    if (px >= ex) begin
      px = 0;
      py++;
      if (py >= ey) begin
        py = 0;
        pos_z++;
        if (pos_z >= ez) begin
          pos_z = 0;
          cell_idx = '0;
        end
      end
    end
    pos_x = px;
    pos_y = py;
  endtask

  // Cell driver: retire the accepted item, then offer the next once its gap has passed.
  int unsigned gap_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cell_valid_i && cell_ready_o) begin
        predict_connections(cell_q.pop_front());
        gap_cnt = 0;
      end
      if (!cell_valid_i || cell_ready_o) begin
        if (cell_q.size() > 0 && gap_cnt >= cell_q[0].gap) begin
          cell_valid_i <= 1'b1;
          cell_dx_i <= cell_q[0].dx;
          cell_dy_i <= cell_q[0].dy;
          cell_dz_i <= cell_q[0].dz;
        end else begin
          cell_valid_i <= 1'b0;
          if (cell_q.size() > 0) gap_cnt++;
        end
      end
    end
  end

  // Connection receiver: random stall per item, plus one long hold-off on request.
  int unsigned rd_wait = 0;
  int unsigned hold_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (conn_valid_o && conn_ready_i) begin
        rd_wait = no_idle ? 0 : $urandom_range(0, 9);
        if (conn_q.size() == 0) begin
          $error("connection with no expectation: lower_cell %0d upper_cell %0d",
                 lower_cell_o, upper_cell_o);
          err_count++;
        end else begin
          conn_item_t e;
          e = conn_q.pop_front();
          if (lower_cell_o !== e.lower_cell) begin
            $error("lower_cell expected %0d actual %0d", e.lower_cell, lower_cell_o);
            err_count++;
          end
          if (upper_cell_o !== e.upper_cell) begin
            $error("upper_cell expected %0d actual %0d", e.upper_cell, upper_cell_o);
            err_count++;
          end
          if (direction_o !== e.direction) begin
            $error("direction expected %0d actual %0d", e.direction, direction_o);
            err_count++;
          end
          if (lower_area_o !== e.lower_area) begin
            $error("lower_area expected %h actual %h", e.lower_area, lower_area_o);
            err_count++;
          end
          if (upper_area_o !== e.upper_area) begin
            $error("upper_area expected %h actual %h", e.upper_area, upper_area_o);
            err_count++;
          end
          if (saturated_o !== e.saturated) begin
            $error("saturated expected %0b actual %0b", e.saturated, saturated_o);
            err_count++;
          end
          if (last_o !== e.last) begin
            $error("last expected %0b actual %0b", e.last, last_o);
            err_count++;
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        conn_ready_i <= 1'b0;
      end else if (rd_wait > 0) begin
        rd_wait--;
        conn_ready_i <= 1'b0;
      end else begin
        conn_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [gnc_pkg::SizeW-1:0] rand_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return gnc_pkg::SizeW'($urandom_range(1, 255));
      2: return '1;
      default: return gnc_pkg::SizeW'($urandom);
    endcase
  endfunction

  task automatic push_cell(logic [gnc_pkg::SizeW-1:0] dx, logic [gnc_pkg::SizeW-1:0] dy,
                           logic [gnc_pkg::SizeW-1:0] dz);
    cell_item_t it;
    it.dx = dx;
    it.dy = dy;
    it.dz = dz;
    it.gap = no_idle ? 0 : $urandom_range(0, 9);
    cell_q = {cell_q, it};
  endtask

  task automatic push_random_cells(int unsigned n);
    repeat (n) push_cell(rand_size(), rand_size(), rand_size());
  endtask

  // Wait for all cells to go in and all connections to come out, then let the block settle.
  task automatic drain();
    while (cell_q.size() > 0 || cell_valid_i || conn_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all three size registers on back-to-back edges; optionally poke the unused index.
  task automatic set_grid(logic [gnc_pkg::CfgDataW-1:0] xs, logic [gnc_pkg::CfgDataW-1:0] ys,
                          logic [gnc_pkg::CfgDataW-1:0] zs, bit poke_none);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= gnc_pkg::CFG_X_SIZE;
    cfg_wdata_i <= xs;
    @(posedge clk_i);
    cfg_index_i <= gnc_pkg::CFG_Y_SIZE;
    cfg_wdata_i <= ys;
    @(posedge clk_i);
    cfg_index_i <= gnc_pkg::CFG_Z_SIZE;
    cfg_wdata_i <= zs;
    if (poke_none) begin
      @(posedge clk_i);
      cfg_index_i <= gnc_pkg::CFG_NONE;
      cfg_wdata_i <= '1;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    x_reg = xs[gnc_pkg::XSizeW-1:0];
    y_reg = ys[gnc_pkg::YSizeW-1:0];
    z_reg = zs;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    cell_idx = '0;
  endtask

  // Reset sizes 1x1x1: every cell starts a new grid, so nothing comes out.
  task automatic test_reset_grid();
    push_random_cells(3);
    drain();
  endtask

  // Area extremes on a 2x2x2 grid, full pass plus wrap into the next grid.
  task automatic test_area_extremes();
    set_grid(gnc_pkg::CfgDataW'(2), gnc_pkg::CfgDataW'(2), gnc_pkg::CfgDataW'(2), 1'b1);
    push_cell('0, 24'h000100, 24'h000100);
    push_cell(24'h000100, '0, 24'h000100);
    push_cell(24'h000100, 24'h000100, '0);
    push_cell('1, '1, '1);
    push_cell(24'h000001, '1, '1);
    push_cell('1, 24'h000001, '1);
    push_cell('1, '1, 24'h000001);
    push_cell(24'h000001, 24'h000001, 24'h000001);
    push_cell(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
    push_cell(24'hAAAAAA, 24'h555555, 24'hF0F0F0);
    drain();
  endtask

  // Small random grids, one full pass plus up to six more cells each.
  task automatic test_random_grids();
    int unsigned xs, ys, zs;
    repeat (8) begin
      xs = $urandom_range(1, 5);
      ys = $urandom_range(1, 4);
      zs = $urandom_range(1, 3);
      set_grid(gnc_pkg::CfgDataW'(xs), gnc_pkg::CfgDataW'(ys), gnc_pkg::CfgDataW'(zs), 1'b0);
      push_random_cells(xs * ys * zs + $urandom_range(0, 6));
      drain();
    end
  endtask

  // Hold the receiver off while cells keep coming, so the block backs up.
  task automatic test_backpressure();
    set_grid(gnc_pkg::CfgDataW'(3), gnc_pkg::CfgDataW'(3), gnc_pkg::CfgDataW'(3), 1'b0);
    hold_req = 1'b1;
    push_random_cells(27);
    drain();
  endtask

  // Clamped size registers: zero and all-ones, then the largest legal layer count.
  task automatic test_size_extremes();
    set_grid('0, '0, '0, 1'b0);
    push_random_cells(3);
    drain();
    set_grid(11'h1FF, 11'h1FF, 11'h7FF, 1'b0);
    no_idle = 1'b1;
    push_random_cells(60);
    drain();
    no_idle = 1'b0;
    push_random_cells(100);
    drain();
    set_grid(gnc_pkg::CfgDataW'(256), gnc_pkg::CfgDataW'(256), gnc_pkg::CfgDataW'(1024),
             1'b0);
    push_random_cells(5);
    drain();
    set_grid(gnc_pkg::CfgDataW'(1), gnc_pkg::CfgDataW'(1), gnc_pkg::CfgDataW'(1024), 1'b0);
    push_random_cells(20);
    drain();
  endtask

  initial begin
    x_reg = gnc_pkg::XSizeW'(1);
    y_reg = gnc_pkg::YSizeW'(1);
    z_reg = gnc_pkg::ZSizeW'(1);
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    cell_idx = '0;
    left_area = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    test_reset_grid();
    test_area_extremes();
    test_random_grids();
    test_backpressure();
    test_size_extremes();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gnc_pkg.sv
rtl/gnc_ram.sv
rtl/gnc_area.sv
rtl/grid_neighbor_connections_top.sv
tb/grid_neighbor_connections_top_test.sv
